// ===== hw/rtl/i2c_srb_pkg.sv =====
`timescale 1ns / 1ps

package i2c_srb_pkg;

    typedef enum logic [2:0] {
        KIND_START      = 3'd0,
        KIND_STOP       = 3'd1,
        KIND_BUS_BYTE   = 3'd2,
        KIND_BUS_TX     = 3'd3,
        KIND_LOCAL_WR   = 3'd4,
        KIND_LOCAL_RD   = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'b001,
        PH_POINTER = 3'b010,
        PH_READ    = 3'b100
    } phase_t;

    typedef struct packed {
        logic wr_lo;
        logic wr_hi;
        logic rd;
    } mem_ctl_t;

    typedef struct packed {
        logic valid;
        logic perr;
        logic byte_mode;
        logic sel_hi;
    } res_ctl_t;

endpackage

// ===== hw/rtl/i2c_srb_in_if.sv =====
`timescale 1ns / 1ps

interface i2c_srb_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [7:0]  bus_byte;
    logic [4:0]  reg_index;
    logic [15:0] reg_value;

    modport source (output valid, kind, bus_byte, reg_index, reg_value, input ready);
    modport sink (input valid, kind, bus_byte, reg_index, reg_value, output ready);
endinterface

// ===== hw/rtl/i2c_srb_out_if.sv =====
`timescale 1ns / 1ps

interface i2c_srb_out_if;
    logic        valid;
    logic        ready;
    logic        data_valid;
    logic [15:0] data;
    logic        pointer_error;

    modport source (output valid, data_valid, data, pointer_error, input ready);
    modport sink (input valid, data_valid, data, pointer_error, output ready);
endinterface

// ===== hw/rtl/i2c_srb_ctrl.sv =====
`timescale 1ns / 1ps

module i2c_srb_ctrl #(
    parameter int NUM_REGS = 32,
    localparam int IDX_W = $clog2(NUM_REGS),
    localparam int POS_W = IDX_W + 1
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  i2c_srb_pkg::kind_t     kind,
    input  logic [7:0]             bus_byte,
    input  logic [4:0]             reg_index,
    input  logic [15:0]            reg_value,
    output i2c_srb_pkg::mem_ctl_t  mem_ctl,
    output logic [IDX_W-1:0]       addr,
    output logic [15:0]            wdata,
    output i2c_srb_pkg::res_ctl_t  res_ctl
);

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(2 * NUM_REGS - 1);

    i2c_srb_pkg::phase_t phase_reg;
    i2c_srb_pkg::phase_t phase_next;
    logic                have_ptr_reg;
    logic                have_ptr_next;
    logic [POS_W-1:0]    pos_reg;
    logic [POS_W-1:0]    pos_next;
    logic [POS_W-1:0]    pos_inc;
    logic                local_ok;

    assign pos_inc  = (pos_reg == LAST_POS) ? '0 : pos_reg + 1'b1;
    assign local_ok = 32'(reg_index) < NUM_REGS;

    always_comb
    begin
        phase_next    = phase_reg;
        have_ptr_next = have_ptr_reg;
        pos_next      = pos_reg;
        mem_ctl       = '0;
        res_ctl       = '0;
        addr          = '0;
        wdata         = '0;
        case (kind)
            i2c_srb_pkg::KIND_START:
            begin
                case (phase_reg)
                    i2c_srb_pkg::PH_IDLE:
                    begin
                        have_ptr_next = 1'b0;
                        phase_next    = i2c_srb_pkg::PH_POINTER;
                    end
                    i2c_srb_pkg::PH_POINTER:
                    begin
                        phase_next = i2c_srb_pkg::PH_READ;
                    end
                    default:
                    begin
                    end
                endcase
            end
            i2c_srb_pkg::KIND_STOP:
            begin
                phase_next = i2c_srb_pkg::PH_IDLE;
            end
            i2c_srb_pkg::KIND_BUS_BYTE:
            begin
                if (phase_reg != i2c_srb_pkg::PH_IDLE)
                begin
                    if (phase_reg == i2c_srb_pkg::PH_POINTER && !have_ptr_reg)
                    begin
                        if (32'(bus_byte) >= NUM_REGS)
                        begin
                            res_ctl.perr = 1'b1;
                            phase_next   = i2c_srb_pkg::PH_IDLE;
                        end
                        else
                        begin
                            pos_next      = {IDX_W'(bus_byte), 1'b0};
                            have_ptr_next = 1'b1;
                        end
                    end
                    else
                    begin
                        mem_ctl.wr_lo = !pos_reg[0];
                        mem_ctl.wr_hi = pos_reg[0];
                        addr          = pos_reg[POS_W-1:1];
                        wdata         = {bus_byte, bus_byte};
                        pos_next      = pos_inc;
                    end
                end
            end
            i2c_srb_pkg::KIND_BUS_TX:
            begin
                if (phase_reg == i2c_srb_pkg::PH_READ)
                begin
                    mem_ctl.rd        = 1'b1;
                    addr              = pos_reg[POS_W-1:1];
                    res_ctl.valid     = 1'b1;
                    res_ctl.byte_mode = 1'b1;
                    res_ctl.sel_hi    = pos_reg[0];
                    pos_next          = pos_inc;
                end
            end
            i2c_srb_pkg::KIND_LOCAL_WR:
            begin
                if (local_ok)
                begin
                    mem_ctl.wr_lo = 1'b1;
                    mem_ctl.wr_hi = 1'b1;
                    addr          = IDX_W'(reg_index);
                    wdata         = reg_value;
                end
            end
            i2c_srb_pkg::KIND_LOCAL_RD:
            begin
                if (local_ok)
                begin
                    mem_ctl.rd    = 1'b1;
                    addr          = IDX_W'(reg_index);
                    res_ctl.valid = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= i2c_srb_pkg::PH_IDLE;
            have_ptr_reg <= 1'b0;
            pos_reg      <= '0;
        end
        else if (en)
        begin
            phase_reg    <= phase_next;
            have_ptr_reg <= have_ptr_next;
            pos_reg      <= pos_next;
        end
    end

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= LAST_POS)
        else $error("Byte pointer left the register file.");

    a_perr_idle: assert property (@(posedge clk) disable iff (!rst_n)
        en && res_ctl.perr |=> phase_reg == i2c_srb_pkg::PH_IDLE)
        else $error("A bad index byte did not return the bank to idle.");

    a_perr_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(res_ctl.perr && (res_ctl.valid || mem_ctl.wr_lo || mem_ctl.wr_hi)))
        else $error("A bad index byte also moved data.");

endmodule

// ===== hw/rtl/i2c_srb_store.sv =====
`timescale 1ns / 1ps

module i2c_srb_store #(
    parameter int NUM_REGS = 32,
    localparam int IDX_W = $clog2(NUM_REGS)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  i2c_srb_pkg::mem_ctl_t mem_ctl,
    input  logic [IDX_W-1:0]      addr,
    input  logic [15:0]           wdata,
    output logic [15:0]           rdata
);

    // Each byte lane has its own valid bit so that an unwritten lane reads as zero.
    logic [7:0]          lo_mem [NUM_REGS];
    logic [7:0]          hi_mem [NUM_REGS];
    logic [NUM_REGS-1:0] lo_vld_reg;
    logic [NUM_REGS-1:0] hi_vld_reg;
    logic [7:0]          rd_lo_reg;
    logic [7:0]          rd_hi_reg;
    logic                rd_lo_vld_reg;
    logic                rd_hi_vld_reg;

    always_ff @(posedge clk)
    begin
        if (en && mem_ctl.wr_lo)
        begin
            lo_mem[addr] <= wdata[7:0];
        end
        if (en && mem_ctl.wr_hi)
        begin
            hi_mem[addr] <= wdata[15:8];
        end
        if (en && mem_ctl.rd)
        begin
            rd_lo_reg <= lo_mem[addr];
            rd_hi_reg <= hi_mem[addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_vld_reg    <= '0;
            hi_vld_reg    <= '0;
            rd_lo_vld_reg <= 1'b0;
            rd_hi_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            if (mem_ctl.wr_lo)
            begin
                lo_vld_reg[addr] <= 1'b1;
            end
            if (mem_ctl.wr_hi)
            begin
                hi_vld_reg[addr] <= 1'b1;
            end
            if (mem_ctl.rd)
            begin
                rd_lo_vld_reg <= lo_vld_reg[addr];
                rd_hi_vld_reg <= hi_vld_reg[addr];
            end
        end
    end

    assign rdata = {rd_hi_vld_reg ? rd_hi_reg : 8'h00, rd_lo_vld_reg ? rd_lo_reg : 8'h00};

endmodule

// ===== hw/rtl/i2c_slave_register_bank_top.sv =====
`timescale 1ns / 1ps

// Register side of an I2C slave with a file of NUM_REGS 16-bit words.
// The cmd channel carries one event per beat: start, stop, received bus byte,
// transmit request, local word write or local word read. The word file is
// seen from the bus as a little-endian byte array with an auto-incrementing
// pointer that wraps over the whole file.
// Every accepted cmd beat produces exactly one rsp beat, which carries
// data_valid, data and pointer_error.
// The rsp beat is valid in the cycle after its cmd beat is accepted. Throughput
// is one beat per cycle while rsp is not stalled, set by the single read and
// write port of the word file.
// When rsp is stalled, the result waits in the output register and cmd.ready
// drops until it is taken; cmd.ready is high whenever that register is empty
// or being drained in the same cycle.
// Reset clears the bus phase, the byte pointer and the pending result, and
// every word of the file reads as zero until written; no clearing pass is
// needed, so a beat can be accepted in the first cycle after reset.
module i2c_slave_register_bank_top #(
    parameter int NUM_REGS = 32
) (
    input logic           clk,
    input logic           rst_n,
    i2c_srb_in_if.sink    cmd,
    i2c_srb_out_if.source rsp
);

    localparam int IDX_W = $clog2(NUM_REGS);

    logic                  accept;
    i2c_srb_pkg::mem_ctl_t mem_ctl;
    i2c_srb_pkg::res_ctl_t res_ctl;
    i2c_srb_pkg::res_ctl_t res_reg;
    logic [IDX_W-1:0]      addr;
    logic [15:0]           wdata;
    logic [15:0]           rdata;
    logic                  out_valid_reg;
    logic                  out_valid_next;

    assign cmd.ready = !out_valid_reg || rsp.ready;
    assign accept    = cmd.valid && cmd.ready;

    i2c_srb_ctrl #(.NUM_REGS(NUM_REGS)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (accept),
        .kind      (i2c_srb_pkg::kind_t'(cmd.kind)),
        .bus_byte  (cmd.bus_byte),
        .reg_index (cmd.reg_index),
        .reg_value (cmd.reg_value),
        .mem_ctl   (mem_ctl),
        .addr      (addr),
        .wdata     (wdata),
        .res_ctl   (res_ctl)
    );

    i2c_srb_store #(.NUM_REGS(NUM_REGS)) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (accept),
        .mem_ctl (mem_ctl),
        .addr    (addr),
        .wdata   (wdata),
        .rdata   (rdata)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                res_reg <= res_ctl;
            end
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.data_valid    = res_reg.valid;
    assign rsp.pointer_error = res_reg.perr;
    assign rsp.data = !res_reg.valid ? 16'h0000 :
                      !res_reg.byte_mode ? rdata :
                      {8'h00, res_reg.sel_hi ? rdata[15:8] : rdata[7:0]};

    a_byte_high_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && res_reg.byte_mode |-> rsp.data[15:8] == 8'h00)
        else $error("A transmitted bus byte carried nonzero high bits.");

    a_no_data_on_err: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.pointer_error |-> !rsp.data_valid && rsp.data == 16'h0000)
        else $error("A pointer error beat carried data.");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !rsp.ready |=> out_valid_reg && $stable(res_reg))
        else $error("A pending result changed while the receiver stalled.");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    localparam int NUM_WORDS = 32;
    localparam int BYTE_SPAN = 2 * NUM_WORDS;
    localparam logic [2:0] KIND_SPARE_LO = 3'd6;
    localparam logic [2:0] KIND_SPARE_HI = 3'd7;
    localparam int RANDOM_BEATS = 950;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic        data_valid;
        logic [15:0] data;
        logic        pointer_error;
    } bank_rsp_t;

    typedef struct {
        logic [2:0]  kind;
        logic [7:0]  bus_byte;
        logic [4:0]  reg_index;
        logic [15:0] reg_value;
        bit          typed;
        bank_rsp_t   want;
    } plan_row_t;

    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_PERIODIC,
        RX_STARVED
    } rx_mode_t;

    logic clk = 1'b0;
    logic rst_n;

    i2c_srb_in_if  cmd_if ();
    i2c_srb_out_if rsp_if ();

    i2c_slave_register_bank_top #(
        .NUM_REGS(NUM_WORDS)
    ) uut (
        .clk  (clk),
        .rst_n(rst_n),
        .cmd  (cmd_if.sink),
        .rsp  (rsp_if.source)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    i2c_srb_pkg::phase_t bus_phase = i2c_srb_pkg::PH_IDLE;
    bit          have_index = 1'b0;
    int          byte_pos = 0;
    logic [15:0] bank [NUM_WORDS];

    bank_rsp_t rsp_due [$];
    plan_row_t plan [$];

    int beats_sent = 0;
    int burst_left = 0;
    int fault_count = 0;
    int n_checked = 0;
    int n_data = 0;
    int n_perr = 0;
    int holds_asked = 0;
    int holds_begun = 0;
    int hold_left = 0;
    rx_mode_t rx_mode = RX_OPEN;
    int rx_mode_left = 0;
    int rx_tick = 0;

    function automatic bank_rsp_t predict_bank(logic [2:0] k, logic [7:0] b,
                                               logic [4:0] ri, logic [15:0] rv);
        bank_rsp_t r;
        int w;
        r = '0;
        w = byte_pos >> 1;
        case (k)
            i2c_srb_pkg::KIND_START:
            begin
                if (bus_phase == i2c_srb_pkg::PH_IDLE)
                begin
                    have_index = 1'b0;
                    bus_phase = i2c_srb_pkg::PH_POINTER;
                end
                else if (bus_phase == i2c_srb_pkg::PH_POINTER)
                begin
                    bus_phase = i2c_srb_pkg::PH_READ;
                end
            end
            i2c_srb_pkg::KIND_STOP:
            begin
                bus_phase = i2c_srb_pkg::PH_IDLE;
            end
            i2c_srb_pkg::KIND_BUS_BYTE:
            begin
                if (bus_phase != i2c_srb_pkg::PH_IDLE)
                begin
                    if (bus_phase == i2c_srb_pkg::PH_POINTER && !have_index)
                    begin
                        if (int'(b) >= NUM_WORDS)
                        begin
                            r.pointer_error = 1'b1;
                            bus_phase = i2c_srb_pkg::PH_IDLE;
                        end
                        else
                        begin
                            byte_pos = 2 * int'(b);
                            have_index = 1'b1;
                        end
                    end
                    else
                    begin
                        if (byte_pos[0])
                            bank[w][15:8] = b;
                        else
                            bank[w][7:0] = b;
                        byte_pos = (byte_pos + 1) % BYTE_SPAN;
                    end
                end
            end
            i2c_srb_pkg::KIND_BUS_TX:
            begin
                if (bus_phase == i2c_srb_pkg::PH_READ)
                begin
                    r.data_valid = 1'b1;
                    r.data = byte_pos[0] ? {8'h00, bank[w][15:8]} : {8'h00, bank[w][7:0]};
                    byte_pos = (byte_pos + 1) % BYTE_SPAN;
                end
            end
            i2c_srb_pkg::KIND_LOCAL_WR:
            begin
                if (int'(ri) < NUM_WORDS)
                    bank[ri] = rv;
            end
            i2c_srb_pkg::KIND_LOCAL_RD:
            begin
                if (int'(ri) < NUM_WORDS)
                begin
                    r.data_valid = 1'b1;
                    r.data = bank[ri];
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    task automatic add_row(logic [2:0] k, logic [7:0] b, logic [4:0] ri, logic [15:0] rv,
                           bit typed, logic dv, logic [15:0] d, logic pe);
        plan_row_t row;
        row.kind = k;
        row.bus_byte = b;
        row.reg_index = ri;
        row.reg_value = rv;
        row.typed = typed;
        row.want = '{data_valid: dv, data: d, pointer_error: pe};
        plan.push_back(row);
    endtask

    task automatic send_beat(logic [2:0] k, logic [7:0] b, logic [4:0] ri, logic [15:0] rv,
                             bit typed, bank_rsp_t want);
        int gap;
        bank_rsp_t predicted;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
            if (gap > 0)
            begin
                cmd_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(40, 1);
        end
        cmd_if.valid <= 1'b1;
        cmd_if.kind <= k;
        cmd_if.bus_byte <= b;
        cmd_if.reg_index <= ri;
        cmd_if.reg_value <= rv;
        @(posedge clk);
        while (!cmd_if.ready) @(posedge clk);
        burst_left--;
        predicted = predict_bank(k, b, ri, rv);
        rsp_due.push_back(typed ? want : predicted);
        beats_sent++;
    endtask

    task automatic send_event(logic [2:0] k, logic [7:0] b);
        send_beat(k, b, 5'($urandom), 16'($urandom), 1'b0, '0);
    endtask

    task automatic send_index_byte();
        if ($urandom_range(7, 0) == 0)
            send_event(i2c_srb_pkg::KIND_BUS_BYTE, 8'($urandom_range(255, NUM_WORDS)));
        else
            send_event(i2c_srb_pkg::KIND_BUS_BYTE, 8'($urandom_range(NUM_WORDS - 1, 0)));
    endtask

    function automatic int pick_length();
        if ($urandom_range(9, 0) == 0)
            return $urandom_range(70, 7);
        return $urandom_range(6, 0);
    endfunction

    task automatic bus_write_txn();
        int n;
        n = pick_length();
        send_event(i2c_srb_pkg::KIND_START, 8'($urandom));
        send_index_byte();
        repeat (n) send_event(i2c_srb_pkg::KIND_BUS_BYTE, 8'($urandom));
        if ($urandom_range(9, 0) != 0)
            send_event(i2c_srb_pkg::KIND_STOP, 8'($urandom));
    endtask

    task automatic bus_read_txn();
        int n;
        n = pick_length();
        send_event(i2c_srb_pkg::KIND_START, 8'($urandom));
        if ($urandom_range(5, 0) != 0)
            send_index_byte();
        send_event(i2c_srb_pkg::KIND_START, 8'($urandom));
        repeat (n)
        begin
            if ($urandom_range(7, 0) == 0)
                send_event(i2c_srb_pkg::KIND_BUS_BYTE, 8'($urandom));
            else
                send_event(i2c_srb_pkg::KIND_BUS_TX, 8'($urandom));
        end
        if ($urandom_range(9, 0) != 0)
            send_event(i2c_srb_pkg::KIND_STOP, 8'($urandom));
    endtask

    task automatic local_access();
        if ($urandom_range(1, 0) == 0)
            send_beat(i2c_srb_pkg::KIND_LOCAL_WR, 8'($urandom), 5'($urandom), 16'($urandom),
                      1'b0, '0);
        else
            send_beat(i2c_srb_pkg::KIND_LOCAL_RD, 8'($urandom), 5'($urandom), 16'($urandom),
                      1'b0, '0);
    endtask

    always @(posedge clk)
    begin
        rx_tick++;
        if (hold_left > 0)
        begin
            rsp_if.ready <= 1'b0;
            hold_left--;
        end
        else if (holds_begun < holds_asked)
        begin
            holds_begun++;
            hold_left = HOLD_CYCLES - 1;
            rsp_if.ready <= 1'b0;
        end
        else
        begin
            if (rx_mode_left == 0)
            begin
                rx_mode = rx_mode_t'($urandom_range(3, 0));
                rx_mode_left = $urandom_range(200, 20);
            end
            rx_mode_left--;
            case (rx_mode)
                RX_OPEN:     rsp_if.ready <= 1'b1;
                RX_COIN:     rsp_if.ready <= 1'($urandom_range(1, 0));
                RX_PERIODIC: rsp_if.ready <= (rx_tick % 5) != 0;
                default:     rsp_if.ready <= ($urandom_range(3, 0) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        bank_rsp_t want;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (rsp_due.size() == 0)
            begin
                fault_count++;
                if (fault_count <= 10)
                    $display("unexpected result: data_valid=%0b data=%h pointer_error=%0b",
                             rsp_if.data_valid, rsp_if.data, rsp_if.pointer_error);
            end
            else
            begin
                want = rsp_due.pop_front();
                n_checked++;
                if (want.data_valid)
                    n_data++;
                if (want.pointer_error)
                    n_perr++;
                if (rsp_if.data_valid !== want.data_valid || rsp_if.data !== want.data ||
                    rsp_if.pointer_error !== want.pointer_error)
                begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display({"mismatch at result %0d: expected dv=%0b data=%h perr=%0b,",
                                  " got dv=%0b data=%h perr=%0b"},
                                 n_checked, want.data_valid, want.data, want.pointer_error,
                                 rsp_if.data_valid, rsp_if.data, rsp_if.pointer_error);
                end
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        bit held;
        bit drained;
        int pick;
        int i;
        held = 1'b0;
        drained = 1'b0;
        foreach (bank[w])
            bank[w] = '0;
        rst_n = 1'b0;
        cmd_if.valid = 1'b0;
        cmd_if.kind = '0;
        cmd_if.bus_byte = '0;
        cmd_if.reg_index = '0;
        cmd_if.reg_value = '0;
        rsp_if.ready = 1'b0;

        add_row(i2c_srb_pkg::KIND_LOCAL_RD, 8'h00, 5'd0, 16'h0000, 1, 1'b1, 16'h0000, 1'b0);
        add_row(i2c_srb_pkg::KIND_LOCAL_RD, 8'hFF, 5'd31, 16'hFFFF, 1, 1'b1, 16'h0000, 1'b0);
        add_row(i2c_srb_pkg::KIND_LOCAL_WR, 8'h00, 5'd31, 16'hFFFF, 1, 1'b0, 16'h0000, 1'b0);
        add_row(i2c_srb_pkg::KIND_LOCAL_RD, 8'h00, 5'd31, 16'h0000, 1, 1'b1, 16'hFFFF, 1'b0);
        add_row(i2c_srb_pkg::KIND_LOCAL_WR, 8'h00, 5'd0, 16'hA55A, 1, 1'b0, 16'h0000, 1'b0);
        add_row(i2c_srb_pkg::KIND_BUS_BYTE, 8'hFF, 5'd0, 16'h0000, 1, 1'b0, 16'h0000, 1'b0);
        add_row(i2c_srb_pkg::KIND_BUS_TX, 8'h00, 5'd0, 16'h0000, 1, 1'b0, 16'h0000, 1'b0);
        add_row(i2c_srb_pkg::KIND_START, 8'h00, 5'd0, 16'h0000, 1, 1'b0, 16'h0000, 1'b0);
        add_row(i2c_srb_pkg::KIND_BUS_BYTE, 8'd32, 5'd0, 16'h0000, 1, 1'b0, 16'h0000, 1'b1);
        add_row(i2c_srb_pkg::KIND_START, 8'h00, 5'd0, 16'h0000, 1, 1'b0, 16'h0000, 1'b0);
        add_row(i2c_srb_pkg::KIND_BUS_BYTE, 8'hFF, 5'd0, 16'h0000, 1, 1'b0, 16'h0000, 1'b1);
        add_row(i2c_srb_pkg::KIND_START, 8'h00, 5'd0, 16'h0000, 1, 1'b0, 16'h0000, 1'b0);
        add_row(i2c_srb_pkg::KIND_BUS_BYTE, 8'd31, 5'd0, 16'h0000, 1, 1'b0, 16'h0000, 1'b0);
        add_row(i2c_srb_pkg::KIND_BUS_BYTE, 8'h12, 5'd0, 16'h0000, 0, 1'b0, 16'h0000, 1'b0);
        add_row(i2c_srb_pkg::KIND_BUS_BYTE, 8'h34, 5'd0, 16'h0000, 0, 1'b0, 16'h0000, 1'b0);
        add_row(i2c_srb_pkg::KIND_BUS_BYTE, 8'h56, 5'd0, 16'h0000, 0, 1'b0, 16'h0000, 1'b0);
        add_row(i2c_srb_pkg::KIND_START, 8'h00, 5'd0, 16'h0000, 0, 1'b0, 16'h0000, 1'b0);
        add_row(i2c_srb_pkg::KIND_BUS_TX, 8'h00, 5'd0, 16'h0000, 0, 1'b0, 16'h0000, 1'b0);
        add_row(i2c_srb_pkg::KIND_BUS_TX, 8'h00, 5'd0, 16'h0000, 0, 1'b0, 16'h0000, 1'b0);
        add_row(i2c_srb_pkg::KIND_BUS_BYTE, 8'h00, 5'd0, 16'h0000, 0, 1'b0, 16'h0000, 1'b0);
        add_row(i2c_srb_pkg::KIND_START, 8'h00, 5'd0, 16'h0000, 0, 1'b0, 16'h0000, 1'b0);
        add_row(i2c_srb_pkg::KIND_STOP, 8'h00, 5'd0, 16'h0000, 1, 1'b0, 16'h0000, 1'b0);
        add_row(i2c_srb_pkg::KIND_LOCAL_RD, 8'h00, 5'd31, 16'h0000, 0, 1'b0, 16'h0000, 1'b0);
        add_row(KIND_SPARE_LO, 8'h00, 5'd0, 16'h0000, 1, 1'b0, 16'h0000, 1'b0);
        add_row(KIND_SPARE_HI, 8'hFF, 5'd31, 16'hFFFF, 1, 1'b0, 16'h0000, 1'b0);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < plan.size(); i++)
            send_beat(plan[i].kind, plan[i].bus_byte, plan[i].reg_index, plan[i].reg_value,
                      plan[i].typed, plan[i].want);

        while (beats_sent < plan.size() + RANDOM_BEATS)
        begin
            if (!held && beats_sent >= 350)
            begin
                held = 1'b1;
                holds_asked++;
            end
            if (!drained && beats_sent >= 650)
            begin
                drained = 1'b1;
                cmd_if.valid <= 1'b0;
                burst_left = 0;
                @(posedge clk);
                while (rsp_due.size() != 0) @(posedge clk);
            end
            pick = $urandom_range(99, 0);
            if (pick < 35)
                bus_write_txn();
            else if (pick < 65)
                bus_read_txn();
            else if (pick < 85)
                local_access();
            else
                send_beat(3'($urandom_range(7, 0)), 8'($urandom), 5'($urandom), 16'($urandom),
                          1'b0, '0);
        end

        cmd_if.valid <= 1'b0;
        @(posedge clk);
        while (rsp_due.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (rsp_due.size() != 0)
            fault_count++;

        $display("summary: %0d beats driven, %0d results checked", beats_sent, n_checked);
        $display("summary: %0d results carried data, %0d flagged a bad register index",
                 n_data, n_perr);
        if (fault_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

// ===== files.f =====
hw/rtl/i2c_srb_pkg.sv
hw/rtl/i2c_srb_in_if.sv
hw/rtl/i2c_srb_out_if.sv
hw/rtl/i2c_srb_ctrl.sv
hw/rtl/i2c_srb_store.sv
hw/rtl/i2c_slave_register_bank_top.sv
tb/testbench.sv
